>>> rtl/core/slha_pkg.sv
// Shared types and constants for the segregated-list heap allocator.
// No dependencies; imported by the allocator top level.
package slha_pkg;

   // Request kinds carried on the request channel's tuser bit.
   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   localparam int unsigned BYTES_W    = 19;
   localparam int unsigned FADDR_W    = 16;
   localparam int unsigned BADDR_W    = 16;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned FLAG_BITS  = 3;

endpackage

>>> rtl/core/slha_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Stand-alone; used for the heap word store of the allocator.
module slha_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_array[addr] <= wdata;
      end
      rdata_ff <= mem_array[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/segregated_list_heap_allocator_top.sv
// Timing is data dependent. An allocate walks size-class lists node by node and rewrites
// headers, footers and links one word per cycle; a free walks the heap block by block
// from its start. Only one item is handled at a time; the single port of the heap word
// store sets the pace. Reset (synchronous, active high) clears control state, then an
// initialization pass writes the prologue, the initial free block and the epilogue before
// the first item is taken.
module segregated_list_heap_allocator_top #(
   parameter int unsigned HEAP_WORDS  = 65536,
   parameter int unsigned NUM_CLASSES = 32,
   parameter int unsigned CHUNK_WORDS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: req_bytes[18:0], free_addr[34:19], zero fill [39:35].
   input  logic [slha_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Fields from bit 0: req_type (0 allocate, 1 free).
   input  logic [0:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: block_addr[15:0].
   output logic [slha_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Fields from bit 0: no_block.
   output logic [0:0]                           rsp_tuser
);

   import slha_pkg::*;

   // Word address width, heap end width, block size width and class index width.
   localparam int unsigned AW = $clog2(HEAP_WORDS);
   localparam int unsigned HW = AW + 1;
   localparam int unsigned SW = (AW + 1 > 18) ? AW + 1 : 18;
   localparam int unsigned CW = $clog2(NUM_CLASSES);
   localparam int unsigned C_EVEN = (CHUNK_WORDS + 1) & ~1;
   localparam int unsigned SMALL_BYTES = CHUNK_WORDS * 4;
   localparam int unsigned INIT_RAW = $clog2(C_EVEN + 1) - 1;
   localparam int unsigned INIT_CLASS = (INIT_RAW > NUM_CLASSES - 1) ? NUM_CLASSES - 1
                                                                       : INIT_RAW;

   typedef enum logic [5:0] {
      S_INIT, S_IDLE, S_DECODE,
      S_FF_HEAD, S_FF_BS, S_FF_CHK, S_FF_S, S_FF_SS, S_FF_HIT, S_FF_UP, S_FF_SCAN, S_FF_TAIL,
      S_GROW, S_GR_E0, S_GR_E1,
      S_PL_RD, S_PL_BS, S_PL_MK2,
      S_MG_RF, S_MG_PV, S_MG_NX, S_MG_NA, S_MG_PVR, S_MG_MK,
      S_INS_HEAD, S_INS_Z1, S_INS_Z2, S_INS_CMP, S_INS_F1, S_INS_F2,
      S_INS_NXT, S_INS_SZ, S_INS_L0, S_INS_L1, S_INS_L2, S_INS_L3,
      S_RM_A, S_RM_B, S_RM_C, S_RM_D, S_RM_E, S_RM_F, S_RM_G,
      S_MK_A, S_MK_B,
      S_FR_CHK, S_FR_HD,
      S_DONE
   } state_type;

   // Smallest power of two not below v, for v of one or more.
   function automatic logic [BYTES_W:0] ceil_pow2(input logic [BYTES_W-1:0] v);
      logic [BYTES_W-1:0] m;
      logic [BYTES_W:0]   r;
      m = v - BYTES_W'(1);
      r = (BYTES_W + 1)'(1);
      for (int i = 0; i < BYTES_W; i++) begin
         if (m[i]) r = (BYTES_W + 1)'(2) << i;
      end
      return r;
   endfunction

   // Request bytes to an even payload word count; zero stays zero.
   function automatic logic [SW-1:0] word_count(input logic [BYTES_W-1:0] bytes);
      logic [BYTES_W:0]   r;
      logic [BYTES_W+1:0] al;
      r = {1'b0, bytes};
      if (bytes == '0) begin
         r = '0;
      end else if (32'(bytes) < 32'(SMALL_BYTES)) begin
         r = ceil_pow2(bytes);
      end
      al = ((BYTES_W + 2)'(r) + (BYTES_W + 2)'(7)) & ~(BYTES_W + 2)'(7);
      return SW'(al >> 2);
   endfunction

   // Size class: floor of log2 of the payload words, capped at the top class.
   function automatic logic [CW-1:0] class_of(input logic [SW-1:0] v);
      int unsigned n;
      n = 0;
      for (int i = 1; i < SW; i++) begin
         if (v[i]) n = i;
      end
      if (n > NUM_CLASSES - 1) n = NUM_CLASSES - 1;
      return CW'(n);
   endfunction

   function automatic logic [WORD_W-1:0] hdr_word(input logic [SW-1:0] sz, input logic al);
      logic [WORD_W-1:0] w;
      w = '0;
      w[SW+FLAG_BITS-1:FLAG_BITS] = sz;
      w[0] = al;
      return w;
   endfunction

   // Heap word store port. All accesses are strictly serialized by the sequencer: one read
   // or one write per cycle, with the read data consumed in the following state, so a read
   // never overlaps a pending write to the same word.
   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] mem_rdata;
   logic [SW-1:0]     rd_sz;
   logic [AW-1:0]     rd_ptr;

   slha_ram #(.WIDTH(WORD_W), .DEPTH(HEAP_WORDS)) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rd_sz  = mem_rdata[SW+FLAG_BITS-1:FLAG_BITS];
   assign rd_ptr = mem_rdata[AW-1:0];

   state_type      state_ff;
   state_type      mk_ret_ff;
   state_type      rm_ret_ff;
   logic [2:0]     init_cnt_ff;
   logic [AW-1:0]  heads_ff [NUM_CLASSES];
   logic [HW-1:0]  heap_end_ff;
   logic           op_ff;
   logic [SW-1:0]  w_ff;
   logic [FADDR_W-1:0] a_ff;
   logic [FADDR_W-1:0] tgt_ff;
   logic [HW-1:0]  p_ff;
   logic [CW-1:0]  cls_ff;
   logic [AW-1:0]  b_ff;
   logic [SW-1:0]  bs_ff;
   logic [AW-1:0]  s_ff;
   logic [AW-1:0]  cur_ff;
   logic [AW-1:0]  prv_ff;
   logic [AW-1:0]  m_h_ff;
   logic [SW-1:0]  m_sz_ff;
   logic [AW-1:0]  pv_ff;
   logic [SW-1:0]  pvsz_ff;
   logic           pa_ff;
   logic [AW-1:0]  mk_h_ff;
   logic [SW-1:0]  mk_sz_ff;
   logic           mk_al_ff;
   logic [AW-1:0]  rm_h_ff;
   logic [SW-1:0]  rm_sz_ff;
   logic [AW-1:0]  rm_p_ff;
   logic [AW-1:0]  rm_s_ff;
   logic [BADDR_W-1:0] res_addr_ff;
   logic           res_nob_ff;
   logic           rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic           rsp_nob_ff;

   // One class-head access per cycle, at an index picked by the current state.
   logic [CW-1:0]  hd_idx;
   logic [AW-1:0]  hd_rd;

   // Grow arithmetic.
   logic [SW-1:0]  ext;
   logic [SW:0]    grow_end;

   // Split test and remnant geometry in placement.
   logic           split_ok;
   logic [AW-1:0]  split_h;
   logic [SW-1:0]  split_sz;

   // Free walk bounds.
   logic           walk_go;

   always_comb begin
      unique case (state_ff)
         S_INS_HEAD: hd_idx = class_of(m_sz_ff);
         S_RM_D:     hd_idx = class_of(rm_sz_ff);
         default:    hd_idx = cls_ff;
      endcase
   end

   assign hd_rd = heads_ff[hd_idx];

   assign ext      = (w_ff > SW'(C_EVEN)) ? w_ff : SW'(C_EVEN);
   assign grow_end = (SW + 1)'(heap_end_ff) + (SW + 1)'(ext) + (SW + 1)'(2);

   assign split_ok = (SW + 1)'(rd_sz) >= (SW + 1)'(w_ff) + (SW + 1)'(2);
   assign split_h  = AW'(SW'(b_ff) + w_ff + SW'(2));
   assign split_sz = rd_sz - w_ff - SW'(2);

   assign walk_go = (p_ff < heap_end_ff - HW'(2)) && (32'(p_ff) <= 32'(tgt_ff));

   // Memory port per state.
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = '0;
      mem_wdata = '0;
      unique case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            unique case (init_cnt_ff)
               3'd0: begin mem_addr = AW'(0); mem_wdata = WORD_W'(1); end
               3'd1: begin mem_addr = AW'(1); mem_wdata = WORD_W'(1); end
               3'd2: begin mem_addr = AW'(2); mem_wdata = hdr_word(SW'(C_EVEN), 1'b0); end
               3'd3: begin mem_addr = AW'(3); mem_wdata = '0; end
               3'd4: begin mem_addr = AW'(4); mem_wdata = '0; end
               3'd5: begin
                  mem_addr = AW'(C_EVEN + 3); mem_wdata = hdr_word(SW'(C_EVEN), 1'b0);
               end
               3'd6: begin mem_addr = AW'(C_EVEN + 4); mem_wdata = WORD_W'(1); end
               default: begin mem_addr = AW'(C_EVEN + 5); mem_wdata = WORD_W'(1); end
            endcase
         end
         S_FF_HEAD: mem_addr = hd_rd;
         S_FF_CHK:  mem_addr = AW'(b_ff + AW'(2));
         S_FF_S:    mem_addr = rd_ptr;
         S_FF_SCAN: mem_addr = AW'(hd_rd + AW'(2));
         S_FF_TAIL: mem_addr = AW'(rd_ptr + AW'(2));
         S_PL_RD:   mem_addr = b_ff;
         S_MK_A: begin
            mem_we = 1'b1; mem_addr = mk_h_ff; mem_wdata = hdr_word(mk_sz_ff, mk_al_ff);
         end
         S_MK_B: begin
            mem_we    = 1'b1;
            mem_addr  = AW'(SW'(mk_h_ff) + mk_sz_ff + SW'(1));
            mem_wdata = hdr_word(mk_sz_ff, mk_al_ff);
         end
         S_GR_E0: begin
            mem_we = 1'b1; mem_addr = AW'(heap_end_ff - HW'(2)); mem_wdata = WORD_W'(1);
         end
         S_GR_E1: begin
            mem_we = 1'b1; mem_addr = AW'(heap_end_ff - HW'(1)); mem_wdata = WORD_W'(1);
         end
         S_MG_RF: mem_addr = AW'(m_h_ff - AW'(1));
         S_MG_PV: mem_addr = AW'(SW'(m_h_ff) - rd_sz - SW'(2));
         S_MG_NX: mem_addr = AW'(SW'(m_h_ff) + m_sz_ff + SW'(2));
         S_FR_CHK: mem_addr = AW'(p_ff);
         S_RM_A: mem_addr = rm_h_ff;
         S_RM_B: mem_addr = AW'(rm_h_ff + AW'(1));
         S_RM_C: mem_addr = AW'(rm_h_ff + AW'(2));
         S_RM_D: begin
            mem_we    = (rm_sz_ff != '0) && (rm_p_ff != '0);
            mem_addr  = AW'(rm_p_ff + AW'(2));
            mem_wdata = WORD_W'(rd_ptr);
         end
         S_RM_E: begin
            mem_we    = (rm_s_ff != '0);
            mem_addr  = AW'(rm_s_ff + AW'(1));
            mem_wdata = WORD_W'(rm_p_ff);
         end
         S_RM_F: begin mem_we = 1'b1; mem_addr = AW'(rm_h_ff + AW'(1)); end
         S_RM_G: begin mem_we = 1'b1; mem_addr = AW'(rm_h_ff + AW'(2)); end
         S_INS_HEAD: mem_addr = hd_rd;
         S_INS_Z1: begin mem_we = 1'b1; mem_addr = AW'(m_h_ff + AW'(1)); end
         S_INS_Z2: begin mem_we = 1'b1; mem_addr = AW'(m_h_ff + AW'(2)); end
         S_INS_CMP: begin
            if (m_sz_ff >= rd_sz) begin
               mem_we    = 1'b1;
               mem_addr  = AW'(cur_ff + AW'(1));
               mem_wdata = WORD_W'(m_h_ff);
            end else begin
               mem_addr = AW'(cur_ff + AW'(2));
            end
         end
         S_INS_F1: begin
            mem_we = 1'b1; mem_addr = AW'(m_h_ff + AW'(2)); mem_wdata = WORD_W'(cur_ff);
         end
         S_INS_F2: begin mem_we = 1'b1; mem_addr = AW'(m_h_ff + AW'(1)); end
         S_INS_NXT: mem_addr = rd_ptr;
         S_INS_SZ:  mem_addr = AW'(cur_ff + AW'(2));
         S_INS_L0: begin
            mem_we = 1'b1; mem_addr = AW'(prv_ff + AW'(2)); mem_wdata = WORD_W'(m_h_ff);
         end
         S_INS_L1: begin
            mem_we = 1'b1; mem_addr = AW'(m_h_ff + AW'(1)); mem_wdata = WORD_W'(prv_ff);
         end
         S_INS_L2: begin
            mem_we = 1'b1; mem_addr = AW'(m_h_ff + AW'(2)); mem_wdata = WORD_W'(cur_ff);
         end
         S_INS_L3: begin
            mem_we = 1'b1; mem_addr = AW'(cur_ff + AW'(1)); mem_wdata = WORD_W'(m_h_ff);
         end
         default: ;
      endcase
   end

   // Sequencer: initialization, allocate search, grow, placement, free walk, coalescing, list insert and remove.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         heap_end_ff  <= HW'(C_EVEN + 6);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i] <= (i == INIT_CLASS) ? AW'(2) : '0;
         end
      end else begin
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               init_cnt_ff <= init_cnt_ff + 3'd1;
               if (init_cnt_ff == 3'd7) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tuser[0];
                  a_ff     <= req_tdata[BYTES_W+FADDR_W-1:BYTES_W];
                  w_ff     <= word_count(req_tdata[BYTES_W-1:0]);
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               res_addr_ff <= '0;
               res_nob_ff  <= 1'b0;
               if (op_ff == REQ_FREE) begin
                  tgt_ff <= a_ff - FADDR_W'(1);
                  p_ff   <= HW'(2);
                  state_ff <= (a_ff >= FADDR_W'(3)) ? S_FR_CHK : S_DONE;
               end else if (w_ff == '0) begin
                  res_nob_ff <= 1'b1;
                  state_ff   <= S_DONE;
               end else begin
                  cls_ff   <= class_of(w_ff);
                  state_ff <= S_FF_HEAD;
               end
            end
            // Tightest fit in the request's own class.
            S_FF_HEAD: begin
               b_ff     <= hd_rd;
               state_ff <= (hd_rd != '0) ? S_FF_BS : S_FF_UP;
            end
            S_FF_BS: begin
               bs_ff    <= rd_sz;
               state_ff <= (rd_sz >= w_ff) ? S_FF_CHK : S_FF_UP;
            end
            S_FF_CHK: begin
               state_ff <= (bs_ff == w_ff) ? S_FF_HIT : S_FF_S;
            end
            S_FF_S: begin
               s_ff     <= rd_ptr;
               state_ff <= (rd_ptr == '0) ? S_FF_HIT : S_FF_SS;
            end
            S_FF_SS: begin
               if (rd_sz < w_ff) begin
                  state_ff <= S_FF_HIT;
               end else begin
                  b_ff     <= s_ff;
                  bs_ff    <= rd_sz;
                  state_ff <= S_FF_CHK;
               end
            end
            // Smallest block of the next non-empty class is its list tail.
            S_FF_UP: begin
               if (cls_ff == CW'(NUM_CLASSES - 1)) begin
                  state_ff <= S_GROW;
               end else begin
                  cls_ff   <= cls_ff + CW'(1);
                  state_ff <= S_FF_SCAN;
               end
            end
            S_FF_SCAN: begin
               b_ff <= hd_rd;
               if (hd_rd != '0) begin
                  state_ff <= S_FF_TAIL;
               end else if (cls_ff == CW'(NUM_CLASSES - 1)) begin
                  state_ff <= S_GROW;
               end else begin
                  cls_ff <= cls_ff + CW'(1);
               end
            end
            S_FF_TAIL: begin
               if (rd_ptr != '0) begin
                  b_ff <= rd_ptr;
               end else begin
                  state_ff <= S_FF_HIT;
               end
            end
            S_FF_HIT: begin
               rm_h_ff   <= b_ff;
               rm_ret_ff <= S_PL_RD;
               state_ff  <= S_RM_A;
            end
            // Extend the heap over the old epilogue.
            S_GROW: begin
               if (grow_end > (SW + 1)'(HEAP_WORDS)) begin
                  res_nob_ff <= 1'b1;
                  state_ff   <= S_DONE;
               end else begin
                  b_ff        <= AW'(heap_end_ff - HW'(2));
                  heap_end_ff <= HW'(grow_end);
                  mk_h_ff     <= AW'(heap_end_ff - HW'(2));
                  mk_sz_ff    <= ext;
                  mk_al_ff    <= 1'b0;
                  mk_ret_ff   <= S_GR_E0;
                  state_ff    <= S_MK_A;
               end
            end
            S_GR_E0: state_ff <= S_GR_E1;
            S_GR_E1: state_ff <= S_PL_RD;
            // Placement with optional split of the surplus.
            S_PL_RD: begin
               res_addr_ff <= BADDR_W'(32'(b_ff) + 32'd1);
               res_nob_ff  <= 1'b0;
               state_ff    <= S_PL_BS;
            end
            S_PL_BS: begin
               mk_al_ff <= 1'b0;
               if (split_ok) begin
                  m_h_ff    <= split_h;
                  m_sz_ff   <= split_sz;
                  mk_h_ff   <= split_h;
                  mk_sz_ff  <= split_sz;
                  mk_ret_ff <= S_PL_MK2;
               end else begin
                  mk_h_ff   <= b_ff;
                  mk_sz_ff  <= rd_sz;
                  mk_al_ff  <= 1'b1;
                  mk_ret_ff <= S_DONE;
               end
               state_ff <= S_MK_A;
            end
            S_PL_MK2: begin
               mk_h_ff   <= b_ff;
               mk_sz_ff  <= w_ff;
               mk_al_ff  <= 1'b1;
               mk_ret_ff <= S_MG_RF;
               state_ff  <= S_MK_A;
            end
            // Coalesce m_h with its heap neighbours, then insert.
            S_MG_RF: state_ff <= S_MG_PV;
            S_MG_PV: begin
               pvsz_ff  <= rd_sz;
               pv_ff    <= AW'(SW'(m_h_ff) - rd_sz - SW'(2));
               state_ff <= S_MG_NX;
            end
            S_MG_NX: begin
               pa_ff    <= mem_rdata[0];
               state_ff <= S_MG_NA;
            end
            S_MG_NA: begin
               if (pa_ff && mem_rdata[0]) begin
                  state_ff <= S_INS_HEAD;
               end else if (!mem_rdata[0]) begin
                  rm_h_ff   <= AW'(SW'(m_h_ff) + m_sz_ff + SW'(2));
                  m_sz_ff   <= m_sz_ff + rd_sz + SW'(2);
                  rm_ret_ff <= S_MG_PVR;
                  state_ff  <= S_RM_A;
               end else begin
                  state_ff <= S_MG_PVR;
               end
            end
            S_MG_PVR: begin
               if (!pa_ff) begin
                  m_sz_ff   <= m_sz_ff + pvsz_ff + SW'(2);
                  m_h_ff    <= pv_ff;
                  rm_h_ff   <= pv_ff;
                  rm_ret_ff <= S_MG_MK;
                  state_ff  <= S_RM_A;
               end else begin
                  state_ff <= S_MG_MK;
               end
            end
            S_MG_MK: begin
               mk_h_ff   <= m_h_ff;
               mk_sz_ff  <= m_sz_ff;
               mk_al_ff  <= 1'b0;
               mk_ret_ff <= S_INS_HEAD;
               state_ff  <= S_MK_A;
            end
            // Sorted insert of m_h; zero-size remnants stay out of every list.
            S_INS_HEAD: begin
               cls_ff <= hd_idx;
               cur_ff <= hd_rd;
               if (m_sz_ff == '0) begin
                  state_ff <= S_DONE;
               end else if (hd_rd == '0) begin
                  heads_ff[hd_idx] <= m_h_ff;
                  state_ff <= S_INS_Z1;
               end else begin
                  state_ff <= S_INS_CMP;
               end
            end
            S_INS_Z1: state_ff <= S_INS_Z2;
            S_INS_Z2: state_ff <= S_DONE;
            S_INS_CMP: begin
               if (m_sz_ff >= rd_sz) begin
                  heads_ff[hd_idx] <= m_h_ff;
                  state_ff <= S_INS_F1;
               end else begin
                  prv_ff   <= cur_ff;
                  state_ff <= S_INS_NXT;
               end
            end
            S_INS_F1: state_ff <= S_INS_F2;
            S_INS_F2: state_ff <= S_DONE;
            S_INS_NXT: begin
               cur_ff   <= rd_ptr;
               state_ff <= (rd_ptr == '0) ? S_INS_L0 : S_INS_SZ;
            end
            S_INS_SZ: begin
               if (rd_sz > m_sz_ff) begin
                  prv_ff   <= cur_ff;
                  state_ff <= S_INS_NXT;
               end else begin
                  state_ff <= S_INS_L0;
               end
            end
            S_INS_L0: state_ff <= S_INS_L1;
            S_INS_L1: state_ff <= S_INS_L2;
            S_INS_L2: state_ff <= (cur_ff != '0) ? S_INS_L3 : S_DONE;
            S_INS_L3: state_ff <= S_DONE;
            // Unlink rm_h from its class list.
            S_RM_A: state_ff <= S_RM_B;
            S_RM_B: begin
               rm_sz_ff <= rd_sz;
               state_ff <= S_RM_C;
            end
            S_RM_C: begin
               rm_p_ff  <= rd_ptr;
               state_ff <= S_RM_D;
            end
            S_RM_D: begin
               rm_s_ff <= rd_ptr;
               if (rm_sz_ff == '0) begin
                  state_ff <= rm_ret_ff;
               end else begin
                  if (rm_p_ff == '0) heads_ff[hd_idx] <= rd_ptr;
                  state_ff <= S_RM_E;
               end
            end
            S_RM_E: state_ff <= S_RM_F;
            S_RM_F: state_ff <= S_RM_G;
            S_RM_G: state_ff <= rm_ret_ff;
            // Header and footer write.
            S_MK_A: state_ff <= S_MK_B;
            S_MK_B: state_ff <= mk_ret_ff;
            // Free: walk the block chain from the first block to the target.
            S_FR_CHK: begin
               state_ff <= walk_go ? S_FR_HD : S_DONE;
            end
            S_FR_HD: begin
               if (32'(p_ff) == 32'(tgt_ff)) begin
                  if (mem_rdata[0]) begin
                     m_h_ff    <= AW'(p_ff);
                     m_sz_ff   <= rd_sz;
                     mk_h_ff   <= AW'(p_ff);
                     mk_sz_ff  <= rd_sz;
                     mk_al_ff  <= 1'b0;
                     mk_ret_ff <= S_MG_RF;
                     state_ff  <= S_MK_A;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  p_ff     <= HW'(SW'(p_ff) + rd_sz + SW'(2));
                  state_ff <= S_FR_CHK;
               end
            end
            // Result register; waits only while an earlier item is still unread.
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_addr_ff;
                  rsp_nob_ff   <= res_nob_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_nob_ff;

`ifndef SYNTHESIS
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("heap store written while idle");

   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(heap_end_ff) <= 32'(HEAP_WORDS)))
      else $error("heap end past the store");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DECODE))
      else $error("accepted item not decoded");

   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("null result carries an address");
`endif

endmodule

>>> bench/tb_segregated_list_heap_allocator_top.sv
// Self-checking testbench for the segregated-list heap allocator top level.
// Depends on slha_pkg and segregated_list_heap_allocator_top; carries its own allocator predictor.
`timescale 1ns / 100ps

module tb_segregated_list_heap_allocator_top;
   import slha_pkg::*;

   localparam int unsigned HEAP_WORDS  = 65536;
   localparam int unsigned NUM_CLASSES = 32;
   localparam int unsigned CHUNK_WORDS = 1024;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // Fields from bit 0: req_bytes[18:0], free_addr[34:19], zero fill [39:35].
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // Fields from bit 0: req_type (0 allocate, 1 free).
   logic [0:0]            req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // Fields from bit 0: block_addr[15:0].
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // Fields from bit 0: no_block.
   logic [0:0]            rsp_tuser;

   segregated_list_heap_allocator_top #(
      .HEAP_WORDS (HEAP_WORDS),
      .NUM_CLASSES(NUM_CLASSES),
      .CHUNK_WORDS(CHUNK_WORDS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One allocator answer: the payload address and the null flag.
   typedef struct packed {
      logic [BADDR_W-1:0] block_addr;
      logic               no_block;
   } alloc_answer_t;

   // ------------------------------------------------------------------
   // Allocator predictor. It keeps its own image of the word store, the
   // class list heads and the heap end, and updates them per accepted item.
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] heap_img [HEAP_WORDS];
   int unsigned       list_head [NUM_CLASSES];
   int unsigned       heap_top;

   function automatic int unsigned heap_rd(input int unsigned a);
      return (a < HEAP_WORDS) ? heap_img[a] : 0;
   endfunction

   function automatic void heap_wr(input int unsigned a, input int unsigned v);
      if (a < HEAP_WORDS) heap_img[a] = v;
   endfunction

   function automatic int unsigned blk_size(input int unsigned h);
      return heap_rd(h) >> FLAG_BITS;
   endfunction

   // Header and footer carry the same tag word.
   function automatic void set_tags(input int unsigned h, input int unsigned sz,
                                    input int unsigned used);
      heap_wr(h, (sz << FLAG_BITS) | used);
      heap_wr(h + sz + 1, (sz << FLAG_BITS) | used);
   endfunction

   function automatic int unsigned size_class(input int unsigned w);
      int unsigned n;
      n = 0;
      while (n < NUM_CLASSES - 1 && w > 1) begin
         n++;
         w >>= 1;
      end
      return n;
   endfunction

   // Insert in descending size order; zero-size remnants stay unlisted.
   function automatic void link_block(input int unsigned h);
      int unsigned sz, c, cur, prv;
      sz = blk_size(h);
      if (sz == 0) return;
      c = size_class(sz);
      cur = list_head[c];
      if (cur == 0) begin
         list_head[c] = h;
         heap_wr(h + 1, 0);
         heap_wr(h + 2, 0);
         return;
      end
      if (sz >= blk_size(cur)) begin
         list_head[c] = h;
         heap_wr(cur + 1, h);
         heap_wr(h + 2, cur);
         heap_wr(h + 1, 0);
         return;
      end
      prv = cur;
      while (cur != 0 && blk_size(cur) > sz) begin
         prv = cur;
         cur = heap_rd(cur + 2);
      end
      heap_wr(prv + 2, h);
      heap_wr(h + 1, prv);
      heap_wr(h + 2, cur);
      if (cur != 0) heap_wr(cur + 1, h);
   endfunction

   function automatic void unlink_block(input int unsigned h);
      int unsigned p, s, sz;
      p = heap_rd(h + 1);
      s = heap_rd(h + 2);
      sz = blk_size(h);
      if (sz == 0) return;
      if (p == 0) list_head[size_class(sz)] = s;
      else heap_wr(p + 2, s);
      if (s != 0) heap_wr(s + 1, p);
      heap_wr(h + 1, 0);
      heap_wr(h + 2, 0);
   endfunction

   function automatic int unsigned coalesce(input int unsigned h);
      int unsigned sz, pv, nx;
      bit pa, na;
      sz = blk_size(h);
      pv = h - ((heap_rd(h - 1) >> FLAG_BITS) + 2);
      nx = h + sz + 2;
      pa = heap_rd(pv) & 1;
      na = heap_rd(nx) & 1;
      if (pa && na) return h;
      if (!na) begin
         unlink_block(nx);
         sz += blk_size(nx) + 2;
      end
      if (!pa) begin
         unlink_block(pv);
         sz += blk_size(pv) + 2;
         h = pv;
      end
      set_tags(h, sz, 0);
      return h;
   endfunction

   // Tightest fit in the own class, else the smallest of the next non-empty class.
   function automatic int unsigned best_fit(input int unsigned w);
      int unsigned c, b, s;
      c = size_class(w);
      b = list_head[c];
      if (b != 0 && blk_size(b) >= w) begin
         forever begin
            if (blk_size(b) == w) return b;
            s = heap_rd(b + 2);
            if (s == 0 || blk_size(s) < w) return b;
            b = s;
         end
      end
      if (c + 1 >= NUM_CLASSES) return 0;
      c++;
      while (list_head[c] == 0 && c + 1 < NUM_CLASSES) c++;
      b = list_head[c];
      if (b != 0)
         while (heap_rd(b + 2) != 0) b = heap_rd(b + 2);
      return b;
   endfunction

   function automatic void split_place(input int unsigned h, input int unsigned w);
      int unsigned bs, nb;
      bs = blk_size(h);
      if (bs >= w + 2) begin
         nb = h + w + 2;
         set_tags(nb, bs - w - 2, 0);
         set_tags(h, w, 1);
         link_block(coalesce(nb));
      end else begin
         set_tags(h, bs, 1);
      end
   endfunction

   function automatic int unsigned extend_heap(input int unsigned w);
      int unsigned ext, h;
      ext = (w > CHUNK_WORDS) ? w : CHUNK_WORDS;
      ext = (ext + 1) & ~32'd1;
      if (longint'(heap_top) + ext + 2 > HEAP_WORDS) return 0;
      h = heap_top - 2;
      set_tags(h, ext, 0);
      heap_top += ext + 2;
      heap_wr(heap_top - 2, 1);
      heap_wr(heap_top - 1, 1);
      return h;
   endfunction

   function automatic void allocator_reset();
      foreach (heap_img[i]) heap_img[i] = '0;
      foreach (list_head[i]) list_head[i] = 0;
      heap_wr(0, 1);
      heap_wr(1, 1);
      heap_wr(2, 1);
      heap_wr(3, 1);
      heap_top = 4;
      link_block(extend_heap(CHUNK_WORDS));
   endfunction

   function automatic alloc_answer_t allocator_step(input req_kind_type kind,
                                                    input int unsigned bytes,
                                                    input int unsigned addr);
      alloc_answer_t ans;
      int unsigned p, w, h, target;
      ans = '0;
      if (kind == REQ_ALLOC) begin
         if (bytes < CHUNK_WORDS * 4) begin
            p = 1;
            if (bytes == 0) p = 0;
            else while (p < bytes) p <<= 1;
            bytes = p;
         end
         if (bytes == 0) begin
            ans.no_block = 1'b1;
         end else begin
            w = ((bytes + 7) & ~32'd7) / 4;
            h = best_fit(w);
            if (h != 0) begin
               unlink_block(h);
               split_place(h, w);
               ans.block_addr = h + 1;
            end else begin
               h = extend_heap(w);
               if (h == 0) ans.no_block = 1'b1;
               else begin
                  split_place(h, w);
                  ans.block_addr = h + 1;
               end
            end
         end
      end else if (addr >= 3 && heap_top >= 4) begin
         // A free only counts when it names an allocated block's payload.
         target = addr - 1;
         p = 2;
         while (p < heap_top - 2 && p <= target) begin
            if (p == target) begin
               if (heap_rd(p) & 1) begin
                  set_tags(p, blk_size(p), 0);
                  link_block(coalesce(p));
               end
               break;
            end
            p += blk_size(p) + 2;
         end
      end
      return ans;
   endfunction

   // ------------------------------------------------------------------
   // Scoreboard state.
   // ------------------------------------------------------------------
   alloc_answer_t   pending_answers[$];
   int unsigned     live_blocks[$];
   int              mismatches = 0;
   int              items_taken = 0;
   int              answers_seen = 0;
   int              null_answers = 0;
   int              frees_taken = 0;

   // Per-item side data; moves with the item so the request monitor sees
   // the values that belong to the item it accepts.
   logic            row_typed = 1'b0;
   alloc_answer_t   row_answer = '0;

   // Idle percentages for each side, set per phase.
   int unsigned     send_idle = 0;
   int unsigned     recv_idle = 0;
   int              hold_asks = 0;
   int              hold_seen = 0;
   int              hold_left = 0;

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Every accepted request runs through the predictor; directed rows
   // with a typed answer use that answer instead of the predicted one.
   always @(posedge clock) begin
      alloc_answer_t got;
      req_kind_type  kind;
      int            idx;
      if (!reset && req_tvalid && req_tready) begin
         kind = req_kind_type'(req_tuser[0]);
         got = allocator_step(kind, req_tdata[BYTES_W-1:0],
                              req_tdata[BYTES_W +: FADDR_W]);
         pending_answers.push_back(row_typed ? row_answer : got);
         items_taken++;
         if (kind == REQ_FREE) begin
            frees_taken++;
            idx = -1;
            foreach (live_blocks[i])
               if (live_blocks[i] == req_tdata[BYTES_W +: FADDR_W]) idx = i;
            if (idx >= 0) live_blocks.delete(idx);
         end else if (got.block_addr != 0) begin
            live_blocks.push_back(got.block_addr);
         end
      end
   end

   // Each accepted result is matched against the oldest expectation.
   always @(posedge clock) begin
      alloc_answer_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answers_seen++;
         if (rsp_tuser[0]) null_answers++;
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected result addr=%0d null=%0b",
                                      rsp_tdata, rsp_tuser[0]));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata !== want.block_addr)
               report_mismatch($sformatf("block_addr got %0d want %0d",
                                         rsp_tdata, want.block_addr));
            if (rsp_tuser[0] !== want.no_block)
               report_mismatch($sformatf("no_block got %0b want %0b",
                                         rsp_tuser[0], want.no_block));
         end
      end
   end

   // Receiver: random stalls per phase, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Offers one item and waits for it to be taken. Valid is only lowered
   // when a gap is rolled, so it never drops and rises in the same step.
   task automatic offer_item(input req_kind_type kind, input int unsigned bytes,
                             input int unsigned addr, input logic typed,
                             input alloc_answer_t answer);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, addr[FADDR_W-1:0], bytes[BYTES_W-1:0]};
      row_typed  <= typed;
      row_answer <= answer;
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits for all outstanding results, then lets the block settle.
   task automatic drain_answers();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // Directed rows: kind, bytes, free address, typed flag, typed answer.
   typedef struct {
      req_kind_type  kind;
      int unsigned   bytes;
      int unsigned   addr;
      logic          typed;
      alloc_answer_t answer;
   } stim_row_t;

   localparam int DIRECTED_ROWS = 22;
   stim_row_t directed [DIRECTED_ROWS] = '{
      // A zero-byte allocate is null.
      '{REQ_ALLOC, 0,      0,     1'b1, '{16'd0, 1'b1}},
      // The first small allocate comes from the initial block at word 2.
      '{REQ_ALLOC, 1,      0,     1'b1, '{16'd3, 1'b0}},
      // As large as the whole store, or a byte less: null, nothing changes.
      '{REQ_ALLOC, 262144, 0,     1'b1, '{16'd0, 1'b1}},
      '{REQ_ALLOC, 262143, 0,     1'b1, '{16'd0, 1'b1}},
      // Frees always answer zero; these are null, past the heap, interior, then the block at 3.
      '{REQ_FREE,  0,      0,     1'b1, '{16'd0, 1'b0}},
      '{REQ_FREE,  0,      65535, 1'b1, '{16'd0, 1'b0}},
      '{REQ_FREE,  0,      4,     1'b1, '{16'd0, 1'b0}},
      '{REQ_FREE,  0,      3,     1'b1, '{16'd0, 1'b0}},
      // Double free of the same block.
      '{REQ_FREE,  0,      3,     1'b1, '{16'd0, 1'b0}},
      '{REQ_ALLOC, 7,      0,     1'b0, '{16'd0, 1'b0}},
      '{REQ_ALLOC, 24,     0,     1'b0, '{16'd0, 1'b0}},
      '{REQ_ALLOC, 4095,   0,     1'b0, '{16'd0, 1'b0}},
      '{REQ_ALLOC, 4096,   0,     1'b0, '{16'd0, 1'b0}},
      '{REQ_ALLOC, 4100,   0,     1'b0, '{16'd0, 1'b0}},
      '{REQ_ALLOC, 40,     0,     1'b0, '{16'd0, 1'b0}},
      // A 48-byte request rounds up to 64 bytes, as the 40-byte one before it does.
      '{REQ_ALLOC, 48,     0,     1'b0, '{16'd0, 1'b0}},
      '{REQ_ALLOC, 131072, 0,     1'b0, '{16'd0, 1'b0}},
      '{REQ_FREE,  0,      5,     1'b0, '{16'd0, 1'b0}},
      '{REQ_FREE,  0,      1036,  1'b0, '{16'd0, 1'b0}},
      '{REQ_ALLOC, 2,      0,     1'b0, '{16'd0, 1'b0}},
      '{REQ_ALLOC, 100000, 0,     1'b0, '{16'd0, 1'b0}},
      '{REQ_FREE,  0,      19,    1'b0, '{16'd0, 1'b0}}
   };

   // Picks a request size: mostly small, some mid, a few very large ones
   // that exercise the heap extension and the exhausted store.
   function automatic int unsigned pick_bytes();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 65) return $urandom_range(64, 1);
      if (r < 88) return $urandom_range(4096, 65);
      if (r < 96) return $urandom_range(24000, 4097);
      if (r < 98) return $urandom_range(262144, 0);
      return ($urandom_range(1) == 0) ? 0 : 262144;
   endfunction

   task automatic random_item();
      int unsigned   r;
      int unsigned   addr;
      alloc_answer_t none;
      none = '0;
      r = $urandom_range(99);
      // Keep the live population bounded so heap walks stay short.
      if (live_blocks.size() > 120 && r < 60) r = 60;
      if (r < 55) begin
         offer_item(REQ_ALLOC, pick_bytes(), $urandom_range(65535), 1'b0, none);
      end else if (r < 90 && live_blocks.size() != 0) begin
         addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
         offer_item(REQ_FREE, $urandom_range(262143), addr, 1'b0, none);
      end else begin
         // Stray frees: random addresses or neighbors of live blocks.
         addr = $urandom_range(65535);
         if ($urandom_range(1) && live_blocks.size() != 0)
            addr = live_blocks[$urandom_range(live_blocks.size() - 1)] +
                   $urandom_range(2) - 1;
         offer_item(REQ_FREE, $urandom_range(262143), addr, 1'b0, none);
      end
   endtask

   initial begin
      allocator_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows with no idling on either side.
      foreach (directed[i])
         offer_item(directed[i].kind, directed[i].bytes, directed[i].addr,
                    directed[i].typed, directed[i].answer);
      drain_answers();

      // Four random phases, each with its own idling mix.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 68; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 68; end
            default: begin send_idle = 20; recv_idle = 20; end
         endcase
         for (int n = 0; n < 195; n++) begin
            // In the first phase the receiver holds off for a long stretch
            // while items keep coming, so the block backs up its input.
            if (ph == 0 && n == 40) hold_asks++;
            random_item();
         end
         // Sender pauses here until every expected result has arrived.
         drain_answers();
      end

      $display("Covered %0d items (%0d frees), %0d results with %0d null answers.",
               items_taken, frees_taken, answers_seen, null_answers);
      $display("Phases ran with no idling, sender gaps, receiver stalls and both.");
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #60_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
